// File: hdl/upp_pkg.sv
package upp_pkg;

   localparam logic signed [17:0] PI_Q13      = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam int ATAN_ENTRIES = 30;
   localparam logic [29:0] ATAN_Q29 [ATAN_ENTRIES] = '{
      30'd421657428, 30'd248918915, 30'd131521918, 30'd66762579, 30'd33510843,
      30'd16771758,  30'd8387925,   30'd4194219,   30'd2097141,  30'd1048575,
      30'd524288,    30'd262144,    30'd131072,    30'd65536,    30'd32768,
      30'd16384,     30'd8192,      30'd4096,      30'd2048,     30'd1024,
      30'd512,       30'd256,       30'd128,       30'd64,       30'd32,
      30'd16,        30'd8,         30'd4,         30'd2,        30'd1
   };

   // multiple of two pi that makes any heading sum non-negative
   localparam logic [46:0] ANG_BIAS   = 47'(64'd51472 << 30);
   // 2^24 mod two pi (Q13)
   localparam logic [15:0] FOLD24     = 16'd48816;
   // floor(2^40 / two pi)
   localparam logic [24:0] RECIP_2PI  = 25'd21361354;
   localparam logic [15:0] TWO_PI_U   = 16'd51472;
   localparam logic [15:0] THR_RESET  = 16'd66;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic              neg;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [31:0] z;
   } cordic_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
   } div_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] hw;
      logic signed [15:0] nh;
      logic               straight;
      logic signed [63:0] prod_v;
      logic signed [63:0] prod_w;
      logic signed [47:0] travel;
      logic [46:0]        ang;
      logic [16:0]        quot;
      logic [47:0]        dnum;
      logic [31:0]        den;
      logic [31:0]        drem;
      logic [31:0]        dlow;
      logic               qneg;
      logic               qbig;
      logic signed [31:0] rad;
      cordic_type         cor1;
      cordic_type         cor2;
      logic signed [33:0] cos1;
      logic signed [33:0] sin1;
      logic signed [33:0] cos2;
      logic signed [33:0] sin2;
      logic signed [47:0] mul_a;
      logic signed [33:0] mul_ca;
      logic signed [33:0] mul_cb;
      logic signed [65:0] pa;
      logic signed [65:0] pb;
      logic signed [50:0] qa;
      logic signed [50:0] qb;
      logic signed [51:0] ma;
      logic signed [51:0] mb;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] jx;
      logic signed [31:0] jy;
      logic signed [15:0] hd;
   } item_type;

   function automatic logic signed [15:0] wrap_heading(input logic signed [15:0] h);
      logic signed [17:0] t;
      t = 18'(h);
      if (t < -PI_Q13) begin
         t = t + TWO_PI_Q13;
      end else if (t >= PI_Q13) begin
         t = t - TWO_PI_Q13;
      end
      return t[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      if (v > 53'(SAT_MAX)) begin
         return SAT_MAX;
      end else if (v < 53'(SAT_MIN)) begin
         return SAT_MIN;
      end
      return v[31:0];
   endfunction

   function automatic cordic_type cordic_init(input logic signed [15:0] h);
      cordic_type r;
      logic signed [17:0] a;
      a = 18'(h);
      r.neg = 1'b0;
      if (a > HALF_PI_Q13) begin
         a = a - PI_Q13;
         r.neg = 1'b1;
      end else if (a < -HALF_PI_Q13) begin
         a = a + PI_Q13;
         r.neg = 1'b1;
      end
      r.x = CORDIC_GAIN_Q30;
      r.y = '0;
      r.z = $signed({a[15:0], 16'b0});
      return r;
   endfunction

   function automatic cordic_type cordic_rot(input cordic_type c, input logic [4:0] sh);
      cordic_type r;
      logic signed [31:0] at;
      at = $signed({2'b0, ATAN_Q29[sh]});
      r.neg = c.neg;
      if (!c.z[31]) begin
         r.x = c.x - (c.y >>> sh);
         r.y = c.y + (c.x >>> sh);
         r.z = c.z - at;
      end else begin
         r.x = c.x + (c.y >>> sh);
         r.y = c.y - (c.x >>> sh);
         r.z = c.z + at;
      end
      return r;
   endfunction

   function automatic div_type div_iter(input div_type d, input logic [31:0] den);
      div_type r;
      logic [32:0] t;
      logic q;
      t = {d.rem, d.low[31]};
      q = (t >= {1'b0, den});
      if (q) begin
         r.rem = 32'(t - {1'b0, den});
      end else begin
         r.rem = t[31:0];
      end
      r.low = {d.low[30:0], q};
      return r;
   endfunction

endpackage

// File: hdl/unicycle_pose_predict_top.sv
// Unicycle pose prediction for an EKF: one prediction per clock, fully pipelined.
// Results leave in order of acceptance. The pipeline depth is set by the CORDIC,
// one rotation per stage with the prior and predicted headings in two side-by-side
// lanes, and by the turn-radius divider, two quotient bits per stage over 16
// stages. Each stage holds its transaction while the next is full, so bubbles
// close up under backpressure. Outputs saturate; the heading wraps to [-pi, pi).
module unicycle_pose_predict_top #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic signed [31:0] req_lin_vel,
   input  logic signed [31:0] req_ang_vel,
   input  logic [31:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_next_x,
   output logic signed [31:0] rsp_next_y,
   output logic signed [15:0] rsp_next_heading,
   output logic signed [31:0] rsp_jac_x_heading,
   output logic signed [31:0] rsp_jac_y_heading,
   output logic               rsp_straight_mode,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);
   import upp_pkg::*;

   localparam int DIV_FIRST  = 2;
   localparam int DIV_STAGES = 16;
   localparam int DF_STG     = DIV_FIRST + DIV_STAGES;
   localparam int CI_STG     = 6;
   localparam int COR_FIRST  = CI_STG + 1;
   localparam int CF_STG     = COR_FIRST + CORDIC_ITERATIONS;
   localparam int MX_STG     = (CF_STG > DF_STG) ? CF_STG + 1 : DF_STG + 1;
   localparam int M1_STG     = MX_STG + 1;
   localparam int M2_STG     = MX_STG + 2;
   localparam int OUT_STG    = MX_STG + 3;
   localparam int NST        = MX_STG + 4;

   logic [15:0]    thr_ff;
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] adv;
   item_type       stg_ff [NST];
   item_type       stg_in [NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   // input capture, heading wrap, mode decision and the two wide products
   always_comb begin
      logic [31:0] vmag;
      logic [31:0] wmag;
      vmag = req_lin_vel[31] ? 32'(-req_lin_vel) : 32'(req_lin_vel);
      wmag = req_ang_vel[31] ? 32'(-req_ang_vel) : 32'(req_ang_vel);
      stg_in[0]          = '0;
      stg_in[0].pos_x    = req_pos_x;
      stg_in[0].pos_y    = req_pos_y;
      stg_in[0].hw       = wrap_heading(req_heading);
      stg_in[0].straight = (wmag < {16'b0, thr_ff}) || (req_ang_vel == '0);
      stg_in[0].prod_v   = req_lin_vel * $signed({1'b0, req_time_step});
      stg_in[0].prod_w   = req_ang_vel * $signed({1'b0, req_time_step});
      stg_in[0].dnum     = {vmag, 16'b0};
      stg_in[0].den      = wmag;
      stg_in[0].qneg     = req_lin_vel[31] ^ req_ang_vel[31];
   end

   for (genvar k = 1; k < NST; k++) begin : g_stage
      localparam bit IS_DIV = (k >= DIV_FIRST) && (k < DF_STG);
      localparam bit IS_COR = (k >= COR_FIRST) && (k < CF_STG);
      localparam logic [4:0] SH = IS_COR ? 5'(k - COR_FIRST) : 5'd0;

      always_comb begin
         item_type           s;
         div_type            dv;
         logic [56:0]        qprod;
         logic [33:0]        rem;
         logic signed [31:0] hi;
         logic signed [65:0] acc_a;
         logic signed [65:0] acc_b;
         logic signed [52:0] ma53;
         logic signed [52:0] mb53;
         s = stg_ff[k-1];
         dv = '0;
         qprod = '0;
         rem = '0;
         hi = '0;
         acc_a = '0;
         acc_b = '0;
         ma53 = '0;
         mb53 = '0;

         if (k == 1) begin
            s.travel = 48'(s.prod_v >>> 16);
            acc_a  = (s.prod_w >>> 19) + 64'(s.hw) + 64'(PI_Q13) + $signed({17'b0, ANG_BIAS});
            s.ang  = acc_a[46:0];
            s.qbig = {16'b0, s.dnum} >= {s.den, 32'b0};
            s.drem = {16'b0, s.dnum[47:32]};
            s.dlow = s.dnum[31:0];
         end

         // heading modulo two pi: two folds, reciprocal estimate, one correction
         if (k == 2) begin
            s.ang = 47'(s.ang[46:24]) * 47'(FOLD24) + 47'(s.ang[23:0]);
         end
         if (k == 3) begin
            s.ang = 47'(s.ang[39:24]) * 47'(FOLD24) + 47'(s.ang[23:0]);
         end
         if (k == 4) begin
            qprod  = 57'(s.ang[31:0]) * 57'(RECIP_2PI);
            s.quot = qprod[56:40];
         end
         if (k == 5) begin
            rem = 34'(s.ang[31:0]) - 34'(s.quot) * 34'(TWO_PI_U);
            if (rem >= 34'(TWO_PI_U)) begin
               rem = rem - 34'(TWO_PI_U);
            end
            s.nh = $signed(16'(rem[16:0] - 17'(PI_Q13)));
         end

         if (k == CI_STG) begin
            s.cor1 = cordic_init(s.hw);
            s.cor2 = cordic_init(s.nh);
         end
         if (IS_COR) begin
            s.cor1 = cordic_rot(s.cor1, SH);
            s.cor2 = cordic_rot(s.cor2, SH);
         end
         if (k == CF_STG) begin
            s.cos1 = s.cor1.neg ? -s.cor1.x : s.cor1.x;
            s.sin1 = s.cor1.neg ? -s.cor1.y : s.cor1.y;
            s.cos2 = s.cor2.neg ? -s.cor2.x : s.cor2.x;
            s.sin2 = s.cor2.neg ? -s.cor2.y : s.cor2.y;
         end

         // turn radius magnitude, restoring division
         if (IS_DIV) begin
            dv.rem = s.drem;
            dv.low = s.dlow;
            dv = div_iter(dv, s.den);
            dv = div_iter(dv, s.den);
            s.drem = dv.rem;
            s.dlow = dv.low;
         end
         if (k == DF_STG) begin
            if (!s.qneg) begin
               s.rad = (s.qbig || s.dlow[31]) ? SAT_MAX : $signed(s.dlow);
            end else begin
               s.rad = (s.qbig || (s.dlow > 32'h80000000)) ? SAT_MIN :
                       $signed(32'(-s.dlow));
            end
         end

         if (k == MX_STG) begin
            s.mul_a  = s.straight ? s.travel : 48'(s.rad);
            s.mul_ca = s.straight ? s.cos1 : s.cos2 - s.cos1;
            s.mul_cb = s.straight ? s.sin1 : s.sin2 - s.sin1;
         end
         if (k == M1_STG) begin
            hi   = 32'(s.mul_a >>> 16);
            s.pa = hi * s.mul_ca;
            s.pb = hi * s.mul_cb;
            s.qa = $signed({1'b0, s.mul_a[15:0]}) * s.mul_ca;
            s.qb = $signed({1'b0, s.mul_a[15:0]}) * s.mul_cb;
         end
         if (k == M2_STG) begin
            acc_a = s.pa + (66'(s.qa) >>> 16);
            acc_b = s.pb + (66'(s.qb) >>> 16);
            s.ma  = 52'(acc_a >>> 14);
            s.mb  = 52'(acc_b >>> 14);
         end
         if (k == OUT_STG) begin
            ma53 = 53'(s.ma);
            mb53 = 53'(s.mb);
            if (s.straight) begin
               s.nx = sat32(53'(s.pos_x) + ma53);
               s.ny = sat32(53'(s.pos_y) + mb53);
               s.jx = sat32(-mb53);
               s.jy = sat32(ma53);
               s.hd = s.hw;
            end else begin
               s.nx = sat32(53'(s.pos_x) + mb53);
               s.ny = sat32(53'(s.pos_y) - ma53);
               s.jx = sat32(ma53);
               s.jy = sat32(mb53);
               s.hd = s.nh;
            end
         end
         stg_in[k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (adv[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign rsp_valid         = vld_ff[NST-1];
   assign rsp_next_x        = stg_ff[NST-1].nx;
   assign rsp_next_y        = stg_ff[NST-1].ny;
   assign rsp_next_heading  = stg_ff[NST-1].hd;
   assign rsp_jac_x_heading = stg_ff[NST-1].jx;
   assign rsp_jac_y_heading = stg_ff[NST-1].jy;
   assign rsp_straight_mode = stg_ff[NST-1].straight;

`ifndef SYNTH
   // an empty output stage lets the whole pipe move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transaction lost at entry stage");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_heading >= -16'sd25736) && (rsp_next_heading <= 16'sd25735))
      else $error("predicted heading outside wrap range");

   a_wrap_stage_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CI_STG] |-> (stg_ff[CI_STG].nh >= -16'sd25736) && (stg_ff[CI_STG].nh <= 16'sd25735))
      else $error("heading modulo out of range");
`endif

endmodule

// File: tb/tb_unicycle_pose_predict_top.sv
`timescale 1ns / 100ps

module tb_unicycle_pose_predict_top;
   import upp_pkg::*;

   localparam int CORDIC_ITER = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef struct packed {
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic signed [15:0] next_heading;
      logic signed [31:0] jac_x;
      logic signed [31:0] jac_y;
      logic               straight;
   } pose_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [15:0] req_heading;
   logic signed [31:0] req_lin_vel;
   logic signed [31:0] req_ang_vel;
   logic [31:0]        req_time_step;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_next_x;
   logic signed [31:0] rsp_next_y;
   logic signed [15:0] rsp_next_heading;
   logic signed [31:0] rsp_jac_x_heading;
   logic signed [31:0] rsp_jac_y_heading;
   logic               rsp_straight_mode;
   logic               csr_wr_en;
   logic [15:0]        csr_wr_data;

   pose_result_type pose_queue[$];
   longint       model_threshold;
   int           error_count;
   int           sent_count;
   int           checked_count;
   int           straight_count;
   int           idle_cycles;
   bit           no_idle;
   bit           rsp_taken;
   int           rsp_stall;
   int           rsp_hold;

   unicycle_pose_predict_top #(
      .CORDIC_ITERATIONS(CORDIC_ITER)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_heading(req_heading),
      .req_lin_vel(req_lin_vel),
      .req_ang_vel(req_ang_vel),
      .req_time_step(req_time_step),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_next_x(rsp_next_x),
      .rsp_next_y(rsp_next_y),
      .rsp_next_heading(rsp_next_heading),
      .rsp_jac_x_heading(rsp_jac_x_heading),
      .rsp_jac_y_heading(rsp_jac_y_heading),
      .rsp_straight_mode(rsp_straight_mode),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint wrap_q13(longint a);
      longint m;
      m = (a + 25736) % 51472;
      if (m < 0) begin
         m = m + 51472;
      end
      return m - 25736;
   endfunction

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint scale_q30(longint a, longint c);
      longint hi;
      longint lo;
      hi = a >>> 16;
      lo = a - hi * 65536;
      return (hi * c + ((lo * c) >>> 16)) >>> 14;
   endfunction

   task automatic rotate_sincos(input longint ang, output longint s, output longint c);
      longint a;
      longint x;
      longint y;
      longint z;
      longint nx;
      longint ny;
      bit     flip;
      a = ang;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (a > 12868) begin
         a = a - 25736;
         flip = 1'b1;
      end else if (a < -12868) begin
         a = a + 25736;
         flip = 1'b1;
      end
      z = a * 65536;
      for (int i = 0; i < CORDIC_ITER && i < ATAN_ENTRIES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z = z - longint'(ATAN_Q29[i]);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z = z + longint'(ATAN_Q29[i]);
         end
         x = nx;
         y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_pose(input longint px, input longint py, input longint hin,
                               input longint v, input longint w, input longint dt,
                               output pose_result_type r);
      longint h;
      longint s1;
      longint c1;
      longint s2;
      longint c2;
      longint d;
      longint rad;
      longint nx;
      longint ny;
      longint nh;
      longint jx;
      longint jy;
      bit     str;
      h = wrap_q13(hin);
      str = ((w < 0 ? -w : w) < model_threshold) || (w == 0);
      rotate_sincos(h, s1, c1);
      if (str) begin
         d = (v * dt) >>> 16;
         nx = px + scale_q30(d, c1);
         ny = py + scale_q30(d, s1);
         nh = h;
         jx = -scale_q30(d, s1);
         jy = scale_q30(d, c1);
      end else begin
         rad = sat_word((v * 65536) / w);
         nh = wrap_q13(h + ((w * dt) >>> 19));
         rotate_sincos(nh, s2, c2);
         jx = scale_q30(rad, c2 - c1);
         jy = scale_q30(rad, s2 - s1);
         nx = px + jy;
         ny = py - jx;
      end
      r.next_x = 32'(sat_word(nx));
      r.next_y = 32'(sat_word(ny));
      r.next_heading = 16'(nh);
      r.jac_x = 32'(sat_word(jx));
      r.jac_y = 32'(sat_word(jy));
      r.straight = str;
   endtask

   task automatic check_field(string name, longint expv, longint actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
         error_count++;
      end
   endtask

   // predict on accepted transaction, check each result, track config writes
   always @(posedge clock) begin
      pose_result_type exp_r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_pose(req_pos_x, req_pos_y, req_heading, req_lin_vel, req_ang_vel,
                         {32'b0, req_time_step}, exp_r);
            pose_queue.push_back(exp_r);
            sent_count++;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (pose_queue.size() == 0) begin
               $error("result with no transaction outstanding");
               error_count++;
            end else begin
               exp_r = pose_queue.pop_front();
               check_field("next_x", exp_r.next_x, rsp_next_x);
               check_field("next_y", exp_r.next_y, rsp_next_y);
               check_field("next_heading", exp_r.next_heading, rsp_next_heading);
               check_field("jac_x_heading", exp_r.jac_x, rsp_jac_x_heading);
               check_field("jac_y_heading", exp_r.jac_y, rsp_jac_y_heading);
               check_field("straight_mode", exp_r.straight, rsp_straight_mode);
               if (rsp_straight_mode) begin
                  straight_count++;
               end
               checked_count++;
            end
         end
         if (csr_wr_en) begin
            model_threshold = csr_wr_data;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall per result, plus an optional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_taken) begin
            rsp_stall = no_idle ? 0 : $urandom_range(0, 19);
            rsp_taken = 1'b0;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                            input logic [15:0] hd, input logic [31:0] v,
                            input logic [31:0] w, input logic [31:0] dt);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      req_lin_vel <= v;
      req_ang_vel <= w;
      req_time_step <= dt;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pose_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] thr);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= thr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'($urandom);
   endtask

   function automatic logic [31:0] pick_word(int span);
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         3: return 32'(0);
         default: return 32'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   task automatic send_random();
      logic [15:0] hd;
      logic [31:0] w;
      logic [31:0] dt;
      hd = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, 51471) - 25736);
      case ($urandom_range(0, 3))
         0: w = 32'($urandom_range(0, 32'(2 * model_threshold + 2)) - model_threshold - 1);
         1: w = pick_word(1 << 20);
         default: w = 32'($urandom_range(0, 1 << 19) - (1 << 18));
      endcase
      dt = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 1 << 18));
      send_item(pick_word(1 << 24), pick_word(1 << 24), hd, pick_word(1 << 21), w, dt);
   endtask

   task automatic test_directed();
      // extremes, wrapping headings, saturation, zero rate and threshold edges
      send_item(0, 0, 16'd0, 0, 0, 0);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd25735, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000, -16'sd25736, 32'h8000_0000, 0, 32'hFFFF_FFFF);
      send_item(0, 0, 16'h7FFF, 32'h0001_0000, 0, 32'h0001_0000);
      send_item(0, 0, 16'h8000, 32'h0001_0000, 0, 32'h0001_0000);
      send_item(0, 0, 16'sd12868, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(0, 0, -16'sd12868, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
      send_item(0, 0, 16'sd12869, 32'h7FFF_FFFF, 32'd66, 32'h0001_0000);
      send_item(0, 0, 16'sd0, 32'h7FFF_FFFF, 32'd65, 32'h0001_0000);
      send_item(0, 0, 16'sd0, 32'h7FFF_FFFF, -32'sd66, 32'hFFFF_FFFF);
      send_item(32'h7FFF_0000, 0, 16'sd20000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(0, 32'h8000_0000, -16'sd20000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'h1234_5678, 32'h8765_4321, 16'sd100, 32'h0002_0000, 32'h0003_0000, 0);
      send_item(0, 0, 16'sd25735, 32'h0001_0000, 32'h0000_8000, 32'h0004_0000);
      write_threshold(16'd0);
      send_item(0, 0, 16'sd0, 32'h0001_0000, 0, 32'h0001_0000);
      send_item(0, 0, 16'sd0, 32'h0001_0000, 32'd1, 32'h0001_0000);
      send_item(0, 0, 16'sd0, 32'h0001_0000, -32'sd1, 32'h0001_0000);
      write_threshold(16'hFFFF);
      send_item(0, 0, 16'sd500, 32'h0001_0000, 32'h0000_FFFF, 32'h0001_0000);
      send_item(0, 0, 16'sd500, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(0, 0, 16'sd500, 32'h0001_0000, 32'hFFFF_0001, 32'h0001_0000);
      write_threshold(16'd66);
   endtask

   task automatic test_threshold_sweep();
      logic [15:0] thr_list[5];
      thr_list = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd66};
      foreach (thr_list[k]) begin
         write_threshold(thr_list[k]);
         repeat (60) send_random();
      end
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < 1100; n++) begin
         if (n % 200 == 0) begin
            no_idle = (n % 400 == 0);
         end
         send_random();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_idle();
      rsp_hold = HOLD_OFF_CYCLES;
      no_idle = 1'b1;
      repeat (80) send_random();
      no_idle = 1'b0;
   endtask

   task automatic test_sender_pause();
      repeat (40) send_random();
      wait_idle();
      repeat (40) send_random();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_heading = '0;
      req_lin_vel = '0;
      req_ang_vel = '0;
      req_time_step = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      model_threshold = 66;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      straight_count = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      rsp_taken = 1'b0;
      rsp_stall = 0;
      rsp_hold = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_threshold_sweep();
      test_random_mix();
      test_backpressure();
      test_sender_pause();
      wait_idle();

      $display("checked %0d of %0d predictions, %0d straight and %0d arc",
               checked_count, sent_count, straight_count, checked_count - straight_count);
      $display("covered threshold extremes, heading wrap, saturation and backpressure");
      if (error_count == 0 && pose_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
